>>> hdl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types and constants of the image rotate and flip frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfb_pkg;

  // Default bounds on the frame dimensions held in the pixel store.
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Largest dimension the registers can select.
  localparam int unsigned DIM_CAP = 256;

  localparam int unsigned DIM_W   = 9;   // width of a dimension register
  localparam int unsigned POS_W   = 8;   // output row and column
  localparam int unsigned LCW     = 17;  // load count, up to 256 * 256
  localparam int unsigned PIX_W   = 24;  // one RGB pixel
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

  typedef enum logic [1:0] {
    MODE_ROT_RIGHT = 2'd0,
    MODE_ROT_LEFT  = 2'd1,
    MODE_FLIP_H    = 2'd2,
    MODE_FLIP_V    = 2'd3
  } mode_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic       last_pixel;
  } out_item_t;

  // Status of the serial divider toward the frame control.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/rfb_ram.sv
// ----------------------------------------------------------------------------
// rfb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ram #(
  parameter int unsigned DW    = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/rfb_div.sv
// ----------------------------------------------------------------------------
// rfb_div
// Restoring divider, one quotient bit per cycle. Splits the load count into
// an input row and column after each configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rfb_pkg::LCW-1:0]   dividend_i,
  input  wire logic [rfb_pkg::DIM_W-1:0] divisor_i,
  output      rfb_pkg::div_stat_t        stat_o,
  output      logic [rfb_pkg::LCW-1:0]   quot_o,
  output      logic [rfb_pkg::DIM_W-1:0] rem_o
);

  import rfb_pkg::*;

  localparam int unsigned CW = $clog2(LCW);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e       state_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [LCW-1:0]   dvd_q;
  logic [DIM_W-1:0] rem_q;
  logic [DIM_W-1:0] dsr_q;

  logic [DIM_W-1:0] shifted;
  logic             fits;
  logic [DIM_W-1:0] rem_d;

  // The remainder stays below the divisor, so its top bit is always clear.
  always_comb begin
    shifted = {rem_q[DIM_W-2:0], dvd_q[LCW-1]};
    fits    = (shifted >= dsr_q);
    rem_d   = fits ? (shifted - dsr_q) : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        state_q <= DIV_RUN;
        cnt_q   <= CW'(LCW - 1);
        dvd_q   <= dividend_i;
        rem_q   <= '0;
        dsr_q   <= divisor_i;
      end else begin
        unique case (state_q)
          DIV_IDLE: begin
          end
          DIV_RUN: begin
            dvd_q <= {dvd_q[LCW-2:0], fits};
            rem_q <= rem_d;
            if (cnt_q == '0) begin
              state_q <= DIV_IDLE;
              done_q  <= 1'b1;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign stat_o.busy = (state_q == DIV_RUN);
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

>>> hdl/image_rotate_flip_buffer.sv
// ----------------------------------------------------------------------------
// image_rotate_flip_buffer
// Frame buffer that rotates an RGB image by 90 degrees or mirrors it.
// ----------------------------------------------------------------------------
// The block takes one load or emit transfer per clock cycle while its input
// is not stalled, as each item is a single access to the one pixel memory.
// An emit result passes through a read stage and the output register, which
// let the input run on while a result waits; the input stalls only when both
// are full. After each configuration write the input stalls while a
// bit-serial divider recomputes the load row and column from the load count.
// The pixel store is not cleared at reset.
`default_nettype none

module image_rotate_flip_buffer #(
  parameter int unsigned MAX_WIDTH  = rfb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rfb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire rfb_pkg::in_item_t             in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      rfb_pkg::out_item_t            out_data_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [rfb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rfb_pkg::DIM_W-1:0]     cfg_wdata_i
);

  import rfb_pkg::*;

  localparam int unsigned CAP_W = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
  localparam int unsigned CAP_H = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;
  localparam int unsigned XW    = $clog2(CAP_W);
  localparam int unsigned YW    = $clog2(CAP_H);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [DIM_W-1:0] CAP_W_D  = DIM_W'(CAP_W);
  localparam logic [DIM_W-1:0] CAP_H_D  = DIM_W'(CAP_H);
  localparam logic [LCW-1:0]   TOTAL_RST = LCW'(CAP_W * CAP_H);

  // Configuration registers.
  mode_e            mode_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             cfg_wr_q;

  // Frame state.
  logic [LCW-1:0]   total_q;
  logic [LCW-1:0]   load_cnt_q;
  logic [XW-1:0]    load_x_q;
  logic [YW-1:0]    load_y_q;
  logic [POS_W-1:0] row_q;
  logic [POS_W-1:0] col_q;

  // Read stage and output register.
  logic             rd_vld_q;
  logic [POS_W-1:0] rd_row_q;
  logic [POS_W-1:0] rd_col_q;
  logic             rd_last_q;
  logic             out_vld_q;
  out_item_t        out_q;

  div_stat_t        div_stat;
  logic [LCW-1:0]   div_quot;
  logic [DIM_W-1:0] div_rem;
  logic [PIX_W-1:0] ram_rdata;

  logic             cfg_fire;
  logic             busy;
  logic             rd_move;
  logic             in_fire;
  logic             frame_full;
  logic             do_load;
  logic             do_emit;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [2*DIM_W-1:0] area;
  logic [DIM_W-1:0]   out_w;
  logic [DIM_W-1:0]   out_h;
  logic               wrap;
  logic [DIM_W-1:0]   r9;
  logic [DIM_W-1:0]   c9;
  logic [DIM_W-1:0]   src_y;
  logic [DIM_W-1:0]   src_x;
  logic               is_last;
  logic               row_end;
  logic               load_row_end;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // A width or height of zero acts as one; anything past the store acts as its limit.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > CAP_W_D) begin
      w_eff = CAP_W_D;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > CAP_H_D) begin
      h_eff = CAP_H_D;
    end else begin
      h_eff = height_q;
    end
    area = w_eff * h_eff;
  end

  assign busy       = cfg_wr_q | div_stat.busy | div_stat.done;
  assign rd_move    = rd_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = busy | (rd_vld_q & ~rd_move);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign frame_full = (load_cnt_q >= total_q);
  assign do_load    = in_fire & (in_data_i.cmd == CMD_LOAD) & ~frame_full;
  assign do_emit    = in_fire & (in_data_i.cmd == CMD_EMIT) & frame_full;

  // Source pixel of the next output position and the load write address.
  always_comb begin
    if ((mode_q == MODE_ROT_RIGHT) || (mode_q == MODE_ROT_LEFT)) begin
      out_w = h_eff;
      out_h = w_eff;
    end else begin
      out_w = w_eff;
      out_h = h_eff;
    end
    // A position left outside the image by a register change restarts at 0,0.
    wrap = (DIM_W'(row_q) >= out_h) || (DIM_W'(col_q) >= out_w);
    r9   = wrap ? '0 : DIM_W'(row_q);
    c9   = wrap ? '0 : DIM_W'(col_q);
    unique case (mode_q)
      MODE_ROT_RIGHT: begin
        src_y = h_eff - 1'b1 - c9;
        src_x = r9;
      end
      MODE_ROT_LEFT: begin
        src_y = c9;
        src_x = w_eff - 1'b1 - r9;
      end
      MODE_FLIP_H: begin
        src_y = r9;
        src_x = w_eff - 1'b1 - c9;
      end
      MODE_FLIP_V: begin
        src_y = h_eff - 1'b1 - r9;
        src_x = c9;
      end
    endcase
    row_end      = ((c9 + 1'b1) >= out_w);
    is_last      = (r9 == (out_h - 1'b1)) && (c9 == (out_w - 1'b1));
    load_row_end = (DIM_W'(load_x_q) == (w_eff - 1'b1));
    raddr        = {src_y[YW-1:0], src_x[XW-1:0]};
    waddr        = {load_y_q, load_x_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ROT_RIGHT;
      width_q    <= DIM_W'(DIM_CAP);
      height_q   <= DIM_W'(DIM_CAP);
      cfg_wr_q   <= 1'b0;
      total_q    <= TOTAL_RST;
      load_cnt_q <= '0;
      load_x_q   <= '0;
      load_y_q   <= '0;
      row_q      <= '0;
      col_q      <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cfg_wr_q <= cfg_fire;
      total_q  <= area[LCW-1:0];

      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_ROTATION_MODE: mode_q   <= mode_e'(cfg_wdata_i[1:0]);
          CFG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i;
          CFG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      if (div_stat.done) begin
        load_x_q <= div_rem[XW-1:0];
        load_y_q <= div_quot[YW-1:0];
      end

      if (do_load) begin
        load_cnt_q <= load_cnt_q + 1'b1;
        if (load_row_end) begin
          load_x_q <= '0;
          load_y_q <= load_y_q + 1'b1;
        end else begin
          load_x_q <= load_x_q + 1'b1;
        end
      end

      if (do_emit) begin
        if (is_last) begin
          load_cnt_q <= '0;
          load_x_q   <= '0;
          load_y_q   <= '0;
          row_q      <= '0;
          col_q      <= '0;
        end else if (row_end) begin
          row_q <= POS_W'(r9 + 1'b1);
          col_q <= '0;
        end else begin
          row_q <= r9[POS_W-1:0];
          col_q <= POS_W'(c9 + 1'b1);
        end
      end

      if (do_emit) begin
        rd_vld_q <= 1'b1;
      end else if (rd_move) begin
        rd_vld_q <= 1'b0;
      end

      if (rd_move) begin
        out_vld_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      rd_row_q  <= r9[POS_W-1:0];
      rd_col_q  <= c9[POS_W-1:0];
      rd_last_q <= is_last;
    end
    if (rd_move) begin
      out_q.red_out    <= ram_rdata[23:16];
      out_q.green_out  <= ram_rdata[15:8];
      out_q.blue_out   <= ram_rdata[7:0];
      out_q.out_row    <= rd_row_q;
      out_q.out_col    <= rd_col_q;
      out_q.last_pixel <= rd_last_q;
    end
  end

  rfb_ram #(
    .DW    (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (waddr),
    .wdata_i ({in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in}),
    .re_i    (do_emit),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  rfb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_wr_q),
    .dividend_i (load_cnt_q),
    .divisor_i  (w_eff),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/rfb_checker.sv
// ----------------------------------------------------------------------------
// rfb_checker
// Port-level checks of the image rotate and flip frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire rfb_pkg::in_item_t             in_data_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire rfb_pkg::out_item_t            out_data_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  import rfb_pkg::*;

  logic emit_xfer;
  assign emit_xfer = in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_EMIT);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A result that appears on an empty output came from an earlier emit transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(emit_xfer, 2))
    else $error("result without a matching emit transfer");

  // The input waits while the load position is recomputed after a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("input taken right after a configuration write");

  // The configuration port never refuses a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind image_rotate_flip_buffer rfb_checker u_rfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
